### src/bytecode_container_header_check_assert.svh
// Assertion shorthands used by the checker file.
`ifndef BYTECODE_CONTAINER_HEADER_CHECK_ASSERT_SVH
`define BYTECODE_CONTAINER_HEADER_CHECK_ASSERT_SVH

// Same-cycle implication, held off during reset
`define BCHC_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("container check assertion failed");

// Next-cycle implication, held off during reset
`define BCHC_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("container check assertion failed");

`endif

### src/bchc_pkg.sv
`default_nettype none

package bchc_pkg;

    // Byte counter width and header geometry
    localparam int COUNT_BITS   = 32;
    localparam int HDR_BYTES    = 56;

    // Queue depths
    localparam int MID_DEPTH    = 4;
    localparam int MID_PTR_BITS = $clog2(MID_DEPTH);
    localparam int RES_DEPTH    = 4;
    localparam int RES_PTR_BITS = $clog2(RES_DEPTH);

    // FNV-1a-64 offset basis
    localparam logic [63:0] FNV_BASIS   = 64'hCBF2_9CE4_8422_2325;

    // Expected magic, little-endian, and the schema / header size word
    localparam logic [63:0] MAGIC_WORD  = 64'h3230_4243_534A_5443;
    localparam logic [63:0] SCHEMA_WORD = 64'h0000_0038_0000_0002;

    typedef logic [COUNT_BITS-1:0] count_t;

    typedef enum logic [3:0] {
        R_OK     = 4'd0,
        R_SHORT  = 4'd1,
        R_MAGIC  = 4'd2,
        R_SCHEMA = 4'd3,
        R_ENGINE = 4'd4,
        R_SOURCE = 4'd5,
        R_URL    = 4'd6,
        R_LENGTH = 4'd7,
        R_HASH   = 4'd8
    } reason_t;

    typedef enum logic [1:0] {
        CFG_ENGINE = 2'd0,
        CFG_SOURCE = 2'd1,
        CFG_URL    = 2'd2
    } cfg_sel_t;

    // Header word groups, one per 8-byte word
    typedef enum logic [2:0] {
        GRP_MAGIC  = 3'd0,
        GRP_SCHEMA = 3'd1,
        GRP_ENGINE = 3'd2,
        GRP_SOURCE = 3'd3,
        GRP_URL    = 3'd4,
        GRP_PHASH  = 3'd5,
        GRP_PLEN   = 3'd6
    } grp_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic        valid_res;
        reason_t     reason;
        logic [31:0] body_length;
    } result_t;

    // Classified item passed from the front end to the back end
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       hdr;
        logic [2:0] lane;
        grp_t       grp;
        logic       ovf;
        count_t     total;
    } mid_item_t;

    // One FNV-1a-64 round; the prime is 2^40 + 2^8 + 0xB3, applied as shift-add
    function automatic logic [63:0] fnv_step(logic [63:0] h, logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

`default_nettype wire

### src/bchc_front.sv
`default_nettype none

module bchc_front
    import bchc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire item_t     item,
    input  wire logic      take,
    output mid_item_t      cls
);

    count_t pos_reg;
    count_t pos_next;
    logic   ovf_reg;
    logic   ovf_next;
    logic   sat;
    logic   hdr;

    // Classify the byte by its position in the container
    always_comb
    begin
        sat      = &pos_reg;
        hdr      = pos_reg < COUNT_BITS'(HDR_BYTES);
        pos_next = sat ? pos_reg : pos_reg + COUNT_BITS'(1);
        ovf_next = ovf_reg | sat;

        cls.data  = item.data_byte;
        cls.last  = item.last_byte;
        cls.hdr   = hdr;
        cls.lane  = pos_reg[2:0];
        cls.grp   = hdr ? grp_t'(pos_reg[5:3]) : GRP_MAGIC;
        cls.ovf   = ovf_next;
        cls.total = pos_next;
    end

    // Advance the byte counter; restart after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (take)
        begin
            if (item.last_byte)
            begin
                pos_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else
            begin
                pos_reg <= pos_next;
                ovf_reg <= ovf_next;
            end
        end
    end

endmodule

`default_nettype wire

### src/bchc_mid_queue.sv
`default_nettype none

module bchc_mid_queue
    import bchc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire mid_item_t wr_item,
    output logic           full,
    input  wire logic      pop,
    output mid_item_t      head,
    output logic           empty
);

    mid_item_t                 mem_reg [MID_DEPTH];
    logic [MID_PTR_BITS-1:0]   wr_ptr_reg;
    logic [MID_PTR_BITS-1:0]   rd_ptr_reg;
    logic [MID_PTR_BITS:0]     cnt_reg;
    logic                      do_push;
    logic                      do_pop;

    assign full    = cnt_reg == (MID_PTR_BITS+1)'(MID_DEPTH);
    assign empty   = cnt_reg == '0;
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Hold item storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + MID_PTR_BITS'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + MID_PTR_BITS'(1);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + (MID_PTR_BITS+1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - (MID_PTR_BITS+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

### src/bchc_back.sv
`default_nettype none

module bchc_back
    import bchc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire mid_item_t   head,
    input  wire logic        mid_empty,
    output logic             mid_pop,
    input  wire logic        pop,
    output logic             empty,
    output result_t          result
);

    // Configuration registers
    logic [63:0] engine_reg;
    logic [63:0] source_reg;
    logic [63:0] url_reg;

    // Stream state
    logic [63:0] asm_reg;
    logic [63:0] asm_next;
    logic [63:0] hash_reg;
    logic [63:0] hash_next;
    logic [63:0] phash_reg;
    logic [63:0] phash_next;
    logic [63:0] plen_reg;
    logic [63:0] plen_next;
    reason_t     err_reg;
    reason_t     err_next;

    // Verdict stage
    logic        fin_v_reg;
    logic        fin_ovf_reg;
    count_t      fin_total_reg;
    reason_t     fin_err_reg;
    logic [63:0] fin_len_reg;
    logic [63:0] fin_phash_reg;
    logic [63:0] fin_hash_reg;

    // Result queue
    result_t                 res_mem_reg [RES_DEPTH];
    logic [RES_PTR_BITS-1:0] res_wr_reg;
    logic [RES_PTR_BITS-1:0] res_rd_reg;
    logic [RES_PTR_BITS:0]   res_cnt_reg;
    logic [RES_PTR_BITS:0]   res_load;

    logic        room;
    logic [63:0] word_base;
    logic [63:0] word;
    logic        word_done;
    logic        bad;
    reason_t     code;
    logic        short_stream;
    logic        len_bad;
    reason_t     verdict;
    result_t     res_new;
    logic        res_pop;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            engine_reg <= '0;
            source_reg <= '0;
            url_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ENGINE: engine_reg <= cfg_data;
                CFG_SOURCE: source_reg <= cfg_data;
                CFG_URL:    url_reg    <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Take an item; a last byte waits until its result has a queue slot
    assign res_load = res_cnt_reg + {{RES_PTR_BITS{1'b0}}, fin_v_reg};
    assign room     = res_load < (RES_PTR_BITS+1)'(RES_DEPTH);
    assign mid_pop  = !mid_empty && (!head.last || room);

    // Assemble header words, check them, run the payload hash
    always_comb
    begin
        word_base  = (head.lane == 3'd0) ? 64'd0 : asm_reg;
        word       = word_base | ({56'd0, head.data} << {head.lane, 3'b000});
        word_done  = head.hdr && (head.lane == 3'd7);
        asm_next   = head.hdr ? word : asm_reg;
        bad        = 1'b0;
        code       = R_OK;
        phash_next = phash_reg;
        plen_next  = plen_reg;
        if (word_done)
        begin
            unique case (head.grp)
                GRP_MAGIC:
                begin
                    bad  = word != MAGIC_WORD;
                    code = R_MAGIC;
                end
                GRP_SCHEMA:
                begin
                    bad  = word != SCHEMA_WORD;
                    code = R_SCHEMA;
                end
                GRP_ENGINE:
                begin
                    bad  = word != engine_reg;
                    code = R_ENGINE;
                end
                GRP_SOURCE:
                begin
                    bad  = word != source_reg;
                    code = R_SOURCE;
                end
                GRP_URL:
                begin
                    bad  = word != url_reg;
                    code = R_URL;
                end
                GRP_PHASH: phash_next = word;
                GRP_PLEN:  plen_next  = word;
                default:   ;
            endcase
        end
        err_next  = (err_reg == R_OK && bad) ? code : err_reg;
        hash_next = head.hdr ? hash_reg : fnv_step(hash_reg, head.data);
    end

    // Hold stream state; clear it after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            asm_reg   <= '0;
            hash_reg  <= FNV_BASIS;
            phash_reg <= '0;
            plen_reg  <= '0;
            err_reg   <= R_OK;
            fin_v_reg <= 1'b0;
        end
        else
        begin
            fin_v_reg <= mid_pop && head.last;
            if (mid_pop)
            begin
                if (head.last)
                begin
                    asm_reg   <= '0;
                    hash_reg  <= FNV_BASIS;
                    phash_reg <= '0;
                    plen_reg  <= '0;
                    err_reg   <= R_OK;
                end
                else
                begin
                    asm_reg   <= asm_next;
                    hash_reg  <= hash_next;
                    phash_reg <= phash_next;
                    plen_reg  <= plen_next;
                    err_reg   <= err_next;
                end
            end
        end
    end

    // Capture the final state of a container
    always_ff @(posedge clk)
    begin
        if (mid_pop && head.last)
        begin
            fin_ovf_reg   <= head.ovf;
            fin_total_reg <= head.total;
            fin_err_reg   <= err_next;
            fin_len_reg   <= plen_next;
            fin_phash_reg <= phash_next;
            fin_hash_reg  <= hash_next;
        end
    end

    // Rank the failures into one verdict
    always_comb
    begin
        short_stream = !fin_ovf_reg && (fin_total_reg < COUNT_BITS'(HDR_BYTES));
        len_bad      = fin_ovf_reg || (fin_len_reg == 64'd0)
                       || (fin_len_reg != 64'(fin_total_reg - COUNT_BITS'(HDR_BYTES)));
        if (short_stream)
        begin
            verdict = R_SHORT;
        end
        else if (fin_err_reg != R_OK)
        begin
            verdict = fin_err_reg;
        end
        else if (len_bad)
        begin
            verdict = R_LENGTH;
        end
        else if (fin_phash_reg != fin_hash_reg)
        begin
            verdict = R_HASH;
        end
        else
        begin
            verdict = R_OK;
        end
        res_new.valid_res   = verdict == R_OK;
        res_new.reason      = verdict;
        res_new.body_length = (verdict == R_OK) ? fin_len_reg[31:0] : 32'd0;
    end

    assign empty   = res_cnt_reg == '0;
    assign result  = res_mem_reg[res_rd_reg];
    assign res_pop = pop && !empty;

    // Hold waiting results
    always_ff @(posedge clk)
    begin
        if (fin_v_reg)
        begin
            res_mem_reg[res_wr_reg] <= res_new;
        end
    end

    // Advance result queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_reg  <= '0;
            res_rd_reg  <= '0;
            res_cnt_reg <= '0;
        end
        else
        begin
            if (fin_v_reg)
            begin
                res_wr_reg <= res_wr_reg + RES_PTR_BITS'(1);
            end
            if (res_pop)
            begin
                res_rd_reg <= res_rd_reg + RES_PTR_BITS'(1);
            end
            if (fin_v_reg && !res_pop)
            begin
                res_cnt_reg <= res_cnt_reg + (RES_PTR_BITS+1)'(1);
            end
            else if (res_pop && !fin_v_reg)
            begin
                res_cnt_reg <= res_cnt_reg - (RES_PTR_BITS+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

### src/bytecode_container_header_check.sv
// Container header check. Bytes go in through a queue-style port (push/full),
// one per cycle sustained while full is low; one verdict per container comes
// out on the byte marked last, through a queue-style port (pop/empty), oldest
// first. A front end counts and classifies bytes into a four-item queue; a
// back end assembles the little-endian header words, checks them, runs
// FNV-1a-64 over the payload and ranks the failures. The payload hash round
// (a shift-add multiply by the prime) is the one-byte-per-cycle loop. A
// verdict goes from the input queue through the verdict registers into a
// four-entry result queue to wait, and full rises only when that queue and
// the input queue both fill. Configuration writes are always ready; indexes
// 0 to 2 select the engine identity, source hash and URL hash; 3 is ignored.
`default_nettype none

module bytecode_container_header_check
    import bchc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire item_t       item,
    input  wire logic        pop,
    output logic             empty,
    output result_t          result,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    mid_item_t cls;
    mid_item_t head;
    logic      mid_empty;
    logic      mid_pop;
    logic      take;

    assign cfg_ready = 1'b1;
    assign take      = push && !full;

    bchc_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .take  (take),
        .cls   (cls)
    );

    bchc_mid_queue u_mid_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (cls),
        .full    (full),
        .pop     (mid_pop),
        .head    (head),
        .empty   (mid_empty)
    );

    bchc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .head      (head),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

`default_nettype wire

### src/bchc_checker.sv
`default_nettype none

`include "bytecode_container_header_check_assert.svh"

module bchc_checker
    import bchc_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        pop,
    input wire logic        empty,
    input wire result_t     result
);

    // A pass verdict carries the ok code and nothing else does
    `BCHC_ASSERT_NOW(a_pass_code, !empty, result.valid_res == (result.reason == R_OK))

    // A failed container reports no payload length
    `BCHC_ASSERT_NOW(a_fail_len, !empty && !result.valid_res, result.body_length == 32'd0)

    // Reason codes stay within the defined set
    `BCHC_ASSERT_NOW(a_reason_range, !empty, result.reason <= R_HASH)

    // A waiting result holds until taken
    `BCHC_ASSERT_NEXT(a_res_hold, !empty && !pop, !empty && $stable(result))

endmodule

bind bytecode_container_header_check bchc_checker u_checker (.*);

`default_nettype wire

### sim/bytecode_container_header_check_test.sv
`timescale 1ns / 100ps

module bytecode_container_header_check_test;
    import bchc_pkg::*;

    localparam int          CYCLE_LIMIT  = 500000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          LONG_HOLD    = 300;
    localparam int          PHASE_BYTES  = 220;
    localparam int          PHASE_FRAMES = 3;
    localparam logic [63:0] FNV_MULT     = 64'd1099511628211;
    // Register index with no register behind it
    localparam logic [1:0]  CFG_UNUSED   = 2'd3;

    // Shapes of container the sender can build
    typedef enum int {
        K_GOOD, K_MAGIC, K_SCHEMA, K_HSIZE, K_ENGINE, K_SOURCE, K_URL, K_PHASH,
        K_PLEN_ZERO, K_PLEN_OFF, K_SHORT, K_SHORT_BADHDR, K_MULTI, K_NOISE
    } frame_kind_t;

    typedef enum int {FILL_ZERO, FILL_ONES, FILL_RAND} fill_t;

    typedef enum int {POP_ALWAYS, POP_HALF, POP_QUARTER, POP_ALTERNATE} pop_mode_t;

    typedef struct {
        frame_kind_t kind;
        int unsigned pay_n;
        fill_t       fill;
        bit          known;
        reason_t     want;
    } dir_row_t;

    typedef struct {
        bit          known;
        reason_t     want;
        logic [31:0] plen;
    } typed_verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    item_t       item = '0;
    logic        pop = 1'b0;
    logic        empty;
    result_t     result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    bytecode_container_header_check i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .pop       (pop),
        .empty     (empty),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Directed containers; want is used only where known is set
    dir_row_t dir_table [18] = '{
        '{K_GOOD,         1,  FILL_ZERO, 1'b1, R_OK},
        '{K_GOOD,         1,  FILL_ONES, 1'b1, R_OK},
        '{K_GOOD,         7,  FILL_RAND, 1'b0, R_OK},
        '{K_SHORT,        1,  FILL_RAND, 1'b1, R_SHORT},
        '{K_SHORT,        55, FILL_RAND, 1'b1, R_SHORT},
        '{K_SHORT_BADHDR, 20, FILL_RAND, 1'b1, R_SHORT},
        '{K_MAGIC,        3,  FILL_RAND, 1'b1, R_MAGIC},
        '{K_SCHEMA,       3,  FILL_RAND, 1'b1, R_SCHEMA},
        '{K_HSIZE,        3,  FILL_RAND, 1'b1, R_SCHEMA},
        '{K_ENGINE,       3,  FILL_RAND, 1'b1, R_ENGINE},
        '{K_SOURCE,       3,  FILL_RAND, 1'b1, R_SOURCE},
        '{K_URL,          3,  FILL_RAND, 1'b1, R_URL},
        '{K_PLEN_ZERO,    4,  FILL_RAND, 1'b1, R_LENGTH},
        '{K_PLEN_OFF,     4,  FILL_RAND, 1'b1, R_LENGTH},
        '{K_GOOD,         0,  FILL_RAND, 1'b1, R_LENGTH},
        '{K_PHASH,        5,  FILL_RAND, 1'b1, R_HASH},
        '{K_MULTI,        6,  FILL_RAND, 1'b1, R_MAGIC},
        '{K_NOISE,        30, FILL_RAND, 1'b0, R_OK}
    };

    // Predictor copy of the registers
    logic [63:0] want_engine = '0;
    logic [63:0] want_source = '0;
    logic [63:0] want_url    = '0;

    // Predictor copy of the stream state
    count_t      pos_cnt    = '0;
    logic [63:0] fnv_acc    = FNV_BASIS;
    logic [63:0] word_acc   = '0;
    logic [63:0] got_phash  = '0;
    logic [63:0] got_plen   = '0;
    reason_t     first_fail = R_OK;
    logic        cnt_sat    = 1'b0;

    result_t        verdicts_due [$];
    typed_verdict_t typed_q [$];
    logic [7:0]     frame_bytes [$];

    int unsigned mismatches     = 0;
    int unsigned bytes_sent     = 0;
    int unsigned frames_sent    = 0;
    int unsigned verdicts_seen  = 0;
    int unsigned seen_reason [9] = '{default: 0};
    int unsigned cycle_count    = 0;
    int          burst_left     = 20;
    int unsigned hold_asked     = 0;
    int unsigned hold_taken     = 0;
    int unsigned hold_left      = 0;
    int unsigned mode_left      = 0;
    pop_mode_t   pop_mode       = POP_ALWAYS;

    result_t        got_want;
    result_t        pred_v;
    bit             pred_made;
    typed_verdict_t typed_v;

    initial begin
        forever #10 clk = ~clk;
    end

    function automatic logic [63:0] fnv_round(logic [63:0] h, logic [7:0] b);
        return (h ^ {56'd0, b}) * FNV_MULT;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got 0x%0h, want 0x%0h (cycle %0d)",
                 what, got, want, cycle_count);
        mismatches++;
    endtask

    // Advance the stream state by one byte; give a verdict on the last byte
    task automatic predict_verdict(input item_t it, output bit made, output result_t v);
        count_t      p;
        count_t      tot;
        logic [2:0]  lane;
        reason_t     rsn;
        p = pos_cnt;
        made = 1'b0;
        v = '0;
        if (p < HDR_BYTES) begin
            lane = p[2:0];
            if (lane == 3'd0)
                word_acc = {56'd0, it.data_byte};
            else
                word_acc = word_acc | ({56'd0, it.data_byte} << (8 * lane));
            if (lane == 3'd7) begin
                case (grp_t'(p[5:3]))
                    GRP_MAGIC:  if (word_acc != MAGIC_WORD && first_fail == R_OK)
                                    first_fail = R_MAGIC;
                    GRP_SCHEMA: if (word_acc != SCHEMA_WORD && first_fail == R_OK)
                                    first_fail = R_SCHEMA;
                    GRP_ENGINE: if (word_acc != want_engine && first_fail == R_OK)
                                    first_fail = R_ENGINE;
                    GRP_SOURCE: if (word_acc != want_source && first_fail == R_OK)
                                    first_fail = R_SOURCE;
                    GRP_URL:    if (word_acc != want_url && first_fail == R_OK)
                                    first_fail = R_URL;
                    GRP_PHASH:  got_phash = word_acc;
                    default:    got_plen = word_acc;
                endcase
            end
        end
        else begin
            fnv_acc = fnv_round(fnv_acc, it.data_byte);
        end

        // Saturate the byte count rather than wrap
        if (&p)
            cnt_sat = 1'b1;
        else
            pos_cnt = p + 1'b1;

        if (it.last_byte) begin
            tot = pos_cnt;
            if (!cnt_sat && tot < HDR_BYTES)
                rsn = R_SHORT;
            else if (first_fail != R_OK)
                rsn = first_fail;
            else if (cnt_sat || got_plen == 64'd0
                     || got_plen != 64'(tot) - 64'(HDR_BYTES))
                rsn = R_LENGTH;
            else if (got_phash != fnv_acc)
                rsn = R_HASH;
            else
                rsn = R_OK;
            made = 1'b1;
            v.valid_res = (rsn == R_OK);
            v.reason = rsn;
            v.body_length = (rsn == R_OK) ? got_plen[31:0] : 32'd0;

            // Drop all stream state, keep the registers
            pos_cnt    = '0;
            fnv_acc    = FNV_BASIS;
            word_acc   = '0;
            got_phash  = '0;
            got_plen   = '0;
            first_fail = R_OK;
            cnt_sat    = 1'b0;
        end
    endtask

    // Offer one item and hold it until taken; idle between bursts
    task automatic send_byte(input logic [7:0] b, input bit last);
        push <= 1'b1;
        item <= '{data_byte: b, last_byte: last};
        @(posedge clk);
        while (full)
            @(posedge clk);
        bytes_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            push <= 1'b0;
            if ($urandom_range(7, 0) == 0)
                repeat ($urandom_range(30, 10)) @(posedge clk);
            else
                repeat ($urandom_range(4, 1)) @(posedge clk);
            if ($urandom_range(9, 0) == 0)
                burst_left = $urandom_range(300, 150);
            else
                burst_left = $urandom_range(40, 1);
        end
    endtask

    // Build one container in frame_bytes and stream it out
    task automatic send_container(input frame_kind_t kind, input int unsigned n,
                                  input fill_t fill, input bit known, input reason_t want);
        logic [7:0]  pay [$];
        logic [63:0] words [7];
        logic [63:0] h;
        bit          is_short;
        is_short = (kind == K_SHORT || kind == K_SHORT_BADHDR);
        if (!is_short) begin
            for (int i = 0; i < n; i++) begin
                case (fill)
                    FILL_ZERO: pay.push_back(8'h00);
                    FILL_ONES: pay.push_back(8'hFF);
                    default:   pay.push_back(8'($urandom));
                endcase
            end
        end
        h = FNV_BASIS;
        foreach (pay[i])
            h = fnv_round(h, pay[i]);

        words[0] = MAGIC_WORD;
        words[1] = SCHEMA_WORD;
        words[2] = want_engine;
        words[3] = want_source;
        words[4] = want_url;
        words[5] = h;
        words[6] = is_short ? 64'd0 : 64'(n);

        // Spoil the chosen header words, by a single bit or by zeroing the length
        case (kind)
            K_MAGIC, K_SHORT_BADHDR:
                words[0] ^= 64'd1 << $urandom_range(63, 0);
            K_SCHEMA:    words[1] ^= 64'd1 << $urandom_range(31, 0);
            K_HSIZE:     words[1] ^= 64'd1 << $urandom_range(63, 32);
            K_ENGINE:    words[2] ^= 64'd1 << $urandom_range(63, 0);
            K_SOURCE:    words[3] ^= 64'd1 << $urandom_range(63, 0);
            K_URL:       words[4] ^= 64'd1 << $urandom_range(63, 0);
            K_PHASH:     words[5] ^= 64'd1 << $urandom_range(63, 0);
            K_PLEN_ZERO: words[6] = 64'd0;
            K_PLEN_OFF:  words[6] ^= 64'd1 << $urandom_range(63, 0);
            K_MULTI:
            begin
                words[0] ^= 64'd1 << $urandom_range(63, 0);
                words[4] ^= 64'd1 << $urandom_range(63, 0);
                words[6] = 64'd0;
            end
            default: ;
        endcase

        frame_bytes.delete();
        if (kind == K_NOISE) begin
            for (int i = 0; i < n; i++)
                frame_bytes.push_back(8'($urandom));
        end
        else begin
            for (int w = 0; w < 7; w++)
                for (int k = 0; k < 8; k++)
                    frame_bytes.push_back(words[w][8*k +: 8]);
            foreach (pay[i])
                frame_bytes.push_back(pay[i]);
            if (is_short)
                while (frame_bytes.size() > n)
                    void'(frame_bytes.pop_back());
        end

        typed_q.push_back('{known: known, want: want, plen: 32'(n)});
        frames_sent++;
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_registers(input logic [63:0] e, input logic [63:0] s,
                                 input logic [63:0] u);
        write_reg(CFG_ENGINE, e);
        write_reg(CFG_SOURCE, s);
        write_reg(CFG_URL, u);
        write_reg(CFG_UNUSED, {$urandom, $urandom});
    endtask

    // Hold input low until every verdict has come, then let the pipe settle
    task automatic wait_all_verdicts();
        push <= 1'b0;
        @(posedge clk);
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Predict on every accepted item and track register writes
    always @(posedge clk) begin
        if (rst_n) begin
            if (push && !full) begin
                predict_verdict(item, pred_made, pred_v);
                if (pred_made) begin
                    if (typed_q.size() != 0) begin
                        typed_v = typed_q.pop_front();
                        if (typed_v.known) begin
                            pred_v.valid_res = (typed_v.want == R_OK);
                            pred_v.reason = typed_v.want;
                            pred_v.body_length =
                                (typed_v.want == R_OK) ? typed_v.plen : 32'd0;
                        end
                    end
                    verdicts_due.push_back(pred_v);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ENGINE: want_engine = cfg_data;
                    CFG_SOURCE: want_source = cfg_data;
                    CFG_URL:    want_url = cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Check each verdict taken against the oldest one due
    always @(posedge clk) begin
        if (rst_n && pop && !empty) begin
            verdicts_seen++;
            if (result.reason <= R_HASH)
                seen_reason[result.reason]++;
            if (verdicts_due.size() == 0) begin
                report_mismatch("verdict with none due, reason", 64'(result.reason), 64'd0);
            end
            else begin
                got_want = verdicts_due.pop_front();
                if (result.valid_res !== got_want.valid_res)
                    report_mismatch("valid_res", 64'(result.valid_res),
                                    64'(got_want.valid_res));
                if (result.reason !== got_want.reason)
                    report_mismatch("reason", 64'(result.reason), 64'(got_want.reason));
                if (result.body_length !== got_want.body_length)
                    report_mismatch("body_length", 64'(result.body_length),
                                    64'(got_want.body_length));
            end
        end
    end

    // Receiver: stall pattern of its own, plus long hold-offs on request
    always @(posedge clk) begin
        if (hold_taken != hold_asked) begin
            hold_taken = hold_asked;
            hold_left = LONG_HOLD;
        end
        if (mode_left == 0) begin
            pop_mode = pop_mode_t'($urandom_range(3, 0));
            mode_left = $urandom_range(128, 32);
        end
        mode_left--;
        if (hold_left != 0) begin
            hold_left--;
            pop <= 1'b0;
        end
        else begin
            case (pop_mode)
                POP_ALWAYS:    pop <= 1'b1;
                POP_HALF:      pop <= 1'($urandom_range(1, 0));
                POP_QUARTER:   pop <= ($urandom_range(3, 0) == 0);
                POP_ALTERNATE: pop <= ~pop;
                default:       pop <= 1'b1;
            endcase
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d verdicts still due",
                     cycle_count, verdicts_due.size());
            $display("bytecode_container_header_check_test NOT OK");
            $finish;
        end
    end

    initial begin
        int unsigned phase_start;
        int unsigned phase_frames;
        int unsigned waited;
        int unsigned pick;
        int unsigned n;
        frame_kind_t kind;
        fill_t       fill;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed containers at the reset register values
        foreach (dir_table[i])
            send_container(dir_table[i].kind, dir_table[i].pay_n, dir_table[i].fill,
                           dir_table[i].known, dir_table[i].want);

        for (int phase = 0; phase < 4; phase++) begin
            wait_all_verdicts();
            case (phase)
                0: set_registers('0, '0, '0);
                1: set_registers('1, '1, '1);
                2: set_registers({$urandom, $urandom}, {$urandom, $urandom},
                                 {$urandom, $urandom});
                default: set_registers(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                                       {$urandom, $urandom});
            endcase

            phase_start = bytes_sent;
            phase_frames = 0;
            while (bytes_sent - phase_start < PHASE_BYTES || phase_frames < PHASE_FRAMES) begin
                // Mostly well-formed containers, the rest broken or noise
                pick = $urandom_range(99, 0);
                if (pick < 68)
                    kind = K_GOOD;
                else if (pick < 93)
                    kind = frame_kind_t'($urandom_range(K_MULTI, K_MAGIC));
                else
                    kind = K_NOISE;

                pick = $urandom_range(99, 0);
                if (kind == K_SHORT)
                    n = $urandom_range(55, 1);
                else if (kind == K_SHORT_BADHDR)
                    n = $urandom_range(55, 8);
                else if (kind == K_NOISE)
                    n = $urandom_range(80, 1);
                else if (pick < 3)
                    n = $urandom_range(300, 150);
                else if (pick < 8)
                    n = 0;
                else
                    n = $urandom_range(24, 1);

                pick = $urandom_range(19, 0);
                fill = (pick == 0) ? FILL_ZERO : (pick == 1) ? FILL_ONES : FILL_RAND;
                send_container(kind, n, fill, 1'b0, R_OK);
                phase_frames++;

                // Fill the block while the receiver holds off
                if (phase == 1 && phase_frames == 2) begin
                    hold_asked++;
                    burst_left = 200;
                    repeat (24) send_container(K_SHORT, 1, FILL_RAND, 1'b1, R_SHORT);
                end
                if (phase == 2 && phase_frames == 3)
                    wait_all_verdicts();
            end
        end

        // Let the last verdicts out, then watch for strays
        push <= 1'b0;
        waited = 0;
        while (verdicts_due.size() != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (verdicts_due.size() != 0)
            report_mismatch("verdicts never delivered", 64'(verdicts_due.size()), 64'd0);

        $display("covered %0d containers in %0d bytes under four register settings;",
                 frames_sent, bytes_sent);
        $display("checked %0d verdicts: ok %0d short %0d magic %0d schema %0d engine %0d %s",
                 verdicts_seen, seen_reason[0], seen_reason[1], seen_reason[2],
                 seen_reason[3], seen_reason[4],
                 $sformatf("source %0d url %0d length %0d hash %0d", seen_reason[5],
                           seen_reason[6], seen_reason[7], seen_reason[8]));
        if (mismatches == 0)
            $display("bytecode_container_header_check_test OK");
        else
            $display("bytecode_container_header_check_test NOT OK");
        $finish;
    end

endmodule
